// ----- rtl/rsfla_pkg.sv -----
package rsfla_pkg;

   localparam int MAX_SLOTS      = 1024;
   localparam int RESERVED_SLOTS = 5;
   localparam int IDX_W          = 10;
   localparam int CNT_W          = 11;
   localparam int HANDLE_W       = 32;
   localparam int STATUS_W       = 3;
   localparam int OP_W           = 2;

   localparam logic [CNT_W-1:0] SLOT_COUNT_RESET = CNT_W'(1024);

   localparam logic [OP_W-1:0] OP_INIT     = 2'd0;
   localparam logic [OP_W-1:0] OP_ALLOC    = 2'd1;
   localparam logic [OP_W-1:0] OP_ALLOC_AT = 2'd2;
   localparam logic [OP_W-1:0] OP_FREE     = 2'd3;

   localparam logic [STATUS_W-1:0] ST_OK           = 3'd0;
   localparam logic [STATUS_W-1:0] ST_NOT_ENABLED  = 3'd1;
   localparam logic [STATUS_W-1:0] ST_FULL         = 3'd2;
   localparam logic [STATUS_W-1:0] ST_BAD_INDEX    = 3'd3;
   localparam logic [STATUS_W-1:0] ST_ALREADY_FREE = 3'd4;

   typedef struct packed {
      logic [OP_W-1:0]     operation;
      logic [IDX_W-1:0]    slot_index;
      logic [HANDLE_W-1:0] handle;
   } req_word_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [IDX_W-1:0]    granted_index;
      logic                overwrote;
      logic                write_valid;
      logic [HANDLE_W-1:0] write_handle;
   } rsp_word_type;

endpackage

// ----- rtl/reserved_slot_free_list_allocator_core.sv -----
// Slot allocator for a handle table, built on a LIFO stack of free indices.
// Input: pulse start with req_word while busy is low; the word is taken at
// that edge and busy stays high until the result is issued.
// Result: rsp_strobe is high for one cycle with rsp_word; the receiver cannot
// stall, so every result is taken in that cycle. Exactly one result per word.
// Configuration: csr_wr_en with csr_wr_data writes slot_count (resets to
// 1024); it is used by the next init.
// States from accept to strobe:
//   not enabled, full, bad index          decided in the decode state
//   allocate, free, already free          decode, then a memory read state
//   allocate at index                     decode, occupancy read, then the stack scan
//   init                                  decode, then the fill of slot_count slots (capped at 1024)
// One single-port read, single-port write stack memory and one occupancy
// memory are shared by all operations; allocate at index scans and compacts
// the stack one entry a cycle, and init fills it one entry a cycle while it
// clears the occupancy bits. A new word is accepted in the cycle the strobe
// is high.
// Reset clears the stack depth and the enable flag; free before init reports
// a bad index.
module reserved_slot_free_list_allocator_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  rsfla_pkg::req_word_type             req_word,
   output logic                                rsp_strobe,
   output rsfla_pkg::rsp_word_type             rsp_word,
   input  logic                                csr_wr_en,
   input  logic [rsfla_pkg::CNT_W-1:0]         csr_wr_data
);

   localparam int IDX_W = rsfla_pkg::IDX_W;
   localparam int CNT_W = rsfla_pkg::CNT_W;

   localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(rsfla_pkg::MAX_SLOTS);
   localparam logic [CNT_W-1:0] RES_CNT = CNT_W'(rsfla_pkg::RESERVED_SLOTS);

   localparam logic [2:0] S_IDLE     = 3'd0;
   localparam logic [2:0] S_DECODE   = 3'd1;
   localparam logic [2:0] S_INIT     = 3'd2;
   localparam logic [2:0] S_ALLOC_RD = 3'd3;
   localparam logic [2:0] S_AT_RD    = 3'd4;
   localparam logic [2:0] S_SCAN     = 3'd5;
   localparam logic [2:0] S_FREE_RD  = 3'd6;

   logic [2:0]                    state_ff, state_in;
   rsfla_pkg::req_word_type       req_ff, req_in;
   logic [CNT_W-1:0]              slot_count_ff, slot_count_in;
   logic [CNT_W-1:0]              active_ff, active_in;
   logic [CNT_W-1:0]              depth_ff, depth_in;
   logic                          enabled_ff, enabled_in;
   logic [CNT_W-1:0]              ptr_ff, ptr_in;
   logic                          pend_ff, pend_in;
   logic [IDX_W-1:0]              pend_addr_ff, pend_addr_in;
   logic                          found_ff, found_in;
   logic                          ow_ff, ow_in;
   logic                          rsp_strobe_ff, rsp_strobe_in;
   rsfla_pkg::rsp_word_type       rsp_word_ff, rsp_word_in;

   logic                          stack_we;
   logic [IDX_W-1:0]              stack_waddr;
   logic [IDX_W-1:0]              stack_wdata;
   logic [IDX_W-1:0]              stack_raddr;
   logic [IDX_W-1:0]              stack_rdata;
   logic                          occ_we;
   logic [IDX_W-1:0]              occ_waddr;
   logic                          occ_wdata;
   logic                          occ_rdata;

   logic [CNT_W-1:0]              depth_m1;
   logic [CNT_W-1:0]              fill_addr;
   logic [CNT_W-1:0]              idx_ext;
   logic                          scan_issue;

   function automatic rsfla_pkg::rsp_word_type make_rsp(
      input logic [rsfla_pkg::STATUS_W-1:0] status,
      input logic [rsfla_pkg::IDX_W-1:0]    index,
      input logic                           overwrote,
      input logic                           write_valid,
      input logic [rsfla_pkg::HANDLE_W-1:0] write_handle
   );
      rsfla_pkg::rsp_word_type w;
      w.status        = status;
      w.granted_index = index;
      w.overwrote     = overwrote;
      w.write_valid   = write_valid;
      w.write_handle  = write_handle;
      return w;
   endfunction

   assign depth_m1   = depth_ff - CNT_W'(1);
   assign fill_addr  = ptr_ff - RES_CNT;
   assign idx_ext    = {1'b0, req_ff.slot_index};
   assign scan_issue = ptr_ff < depth_ff;
   assign stack_raddr = (state_ff == S_SCAN) ? ptr_ff[IDX_W-1:0] : depth_m1[IDX_W-1:0];

   rsfla_ram #(
      .WIDTH (IDX_W),
      .DEPTH (rsfla_pkg::MAX_SLOTS)
   ) u_stack (
      .clock   (clock),
      .wr_en   (stack_we),
      .wr_addr (stack_waddr),
      .wr_data (stack_wdata),
      .rd_addr (stack_raddr),
      .rd_data (stack_rdata)
   );

   rsfla_ram #(
      .WIDTH (1),
      .DEPTH (rsfla_pkg::MAX_SLOTS)
   ) u_occ (
      .clock   (clock),
      .wr_en   (occ_we),
      .wr_addr (occ_waddr),
      .wr_data (occ_wdata),
      .rd_addr (req_ff.slot_index),
      .rd_data (occ_rdata)
   );

   always_comb begin
      state_in      = state_ff;
      req_in        = req_ff;
      slot_count_in = slot_count_ff;
      active_in     = active_ff;
      depth_in      = depth_ff;
      enabled_in    = enabled_ff;
      ptr_in        = ptr_ff;
      pend_in       = pend_ff;
      pend_addr_in  = pend_addr_ff;
      found_in      = found_ff;
      ow_in         = ow_ff;
      rsp_strobe_in = 1'b0;
      rsp_word_in   = rsp_word_ff;
      stack_we      = 1'b0;
      stack_waddr   = depth_ff[IDX_W-1:0];
      stack_wdata   = req_ff.slot_index;
      occ_we        = 1'b0;
      occ_waddr     = req_ff.slot_index;
      occ_wdata     = 1'b0;

      if (csr_wr_en) begin
         slot_count_in = csr_wr_data;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               req_in   = req_word;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            unique case (req_ff.operation)
               rsfla_pkg::OP_INIT: begin
                  active_in = (slot_count_ff > MAX_CNT) ? MAX_CNT : slot_count_ff;
                  ptr_in    = '0;
                  state_in  = S_INIT;
               end
               rsfla_pkg::OP_ALLOC: begin
                  if (!enabled_ff) begin
                     rsp_strobe_in = 1'b1;
                     rsp_word_in   = make_rsp(rsfla_pkg::ST_NOT_ENABLED, '0, 1'b0, 1'b0, '0);
                     state_in      = S_IDLE;
                  end else if (depth_ff == '0) begin
                     rsp_strobe_in = 1'b1;
                     rsp_word_in   = make_rsp(rsfla_pkg::ST_FULL, '0, 1'b0, 1'b0, '0);
                     state_in      = S_IDLE;
                  end else begin
                     state_in = S_ALLOC_RD;
                  end
               end
               rsfla_pkg::OP_ALLOC_AT: begin
                  if (!enabled_ff) begin
                     rsp_strobe_in = 1'b1;
                     rsp_word_in   = make_rsp(rsfla_pkg::ST_NOT_ENABLED, '0, 1'b0, 1'b0, '0);
                     state_in      = S_IDLE;
                  end else if (idx_ext >= active_ff) begin
                     rsp_strobe_in = 1'b1;
                     rsp_word_in   = make_rsp(rsfla_pkg::ST_BAD_INDEX, '0, 1'b0, 1'b0, '0);
                     state_in      = S_IDLE;
                  end else begin
                     state_in = S_AT_RD;
                  end
               end
               rsfla_pkg::OP_FREE: begin
                  if (idx_ext >= active_ff) begin
                     rsp_strobe_in = 1'b1;
                     rsp_word_in   = make_rsp(rsfla_pkg::ST_BAD_INDEX, '0, 1'b0, 1'b0, '0);
                     state_in      = S_IDLE;
                  end else begin
                     state_in = S_FREE_RD;
                  end
               end
               default: begin
                  state_in = S_IDLE;
               end
            endcase
         end
         S_INIT: begin
            if (ptr_ff != active_ff) begin
               occ_we    = 1'b1;
               occ_waddr = ptr_ff[IDX_W-1:0];
               occ_wdata = 1'b0;
               if (ptr_ff >= RES_CNT) begin
                  stack_we    = 1'b1;
                  stack_waddr = fill_addr[IDX_W-1:0];
                  stack_wdata = ptr_ff[IDX_W-1:0];
               end
               ptr_in = ptr_ff + CNT_W'(1);
            end else begin
               depth_in      = (active_ff > RES_CNT) ? (active_ff - RES_CNT) : '0;
               enabled_in    = 1'b1;
               rsp_strobe_in = 1'b1;
               rsp_word_in   = make_rsp(rsfla_pkg::ST_OK, '0, 1'b0, 1'b0, '0);
               state_in      = S_IDLE;
            end
         end
         S_ALLOC_RD: begin
            occ_we        = 1'b1;
            occ_waddr     = stack_rdata;
            occ_wdata     = 1'b1;
            depth_in      = depth_m1;
            rsp_strobe_in = 1'b1;
            rsp_word_in   = make_rsp(rsfla_pkg::ST_OK, stack_rdata, 1'b0, 1'b1, req_ff.handle);
            state_in      = S_IDLE;
         end
         S_AT_RD: begin
            occ_we    = 1'b1;
            occ_wdata = 1'b1;
            ow_in     = occ_rdata;
            ptr_in    = '0;
            pend_in   = 1'b0;
            found_in  = 1'b0;
            state_in  = S_SCAN;
         end
         S_SCAN: begin
            pend_in = scan_issue;
            if (scan_issue) begin
               ptr_in       = ptr_ff + CNT_W'(1);
               pend_addr_in = ptr_ff[IDX_W-1:0];
            end
            if (pend_ff) begin
               if (found_ff) begin
                  stack_we    = 1'b1;
                  stack_waddr = pend_addr_ff - IDX_W'(1);
                  stack_wdata = stack_rdata;
               end else if (stack_rdata == req_ff.slot_index) begin
                  found_in = 1'b1;
               end
            end
            if (!scan_issue && !pend_ff) begin
               if (found_ff) begin
                  depth_in = depth_m1;
               end
               rsp_strobe_in = 1'b1;
               rsp_word_in   = make_rsp(rsfla_pkg::ST_OK, req_ff.slot_index, ow_ff, 1'b1,
                                        req_ff.handle);
               state_in      = S_IDLE;
            end
         end
         S_FREE_RD: begin
            rsp_strobe_in = 1'b1;
            state_in      = S_IDLE;
            if (!occ_rdata) begin
               rsp_word_in = make_rsp(rsfla_pkg::ST_ALREADY_FREE, '0, 1'b0, 1'b0, '0);
            end else begin
               occ_we    = 1'b1;
               occ_wdata = 1'b0;
               if (depth_ff != MAX_CNT) begin
                  stack_we = 1'b1;
                  depth_in = depth_ff + CNT_W'(1);
               end
               rsp_word_in = make_rsp(rsfla_pkg::ST_OK, req_ff.slot_index, 1'b0, 1'b0, '0);
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         slot_count_ff <= rsfla_pkg::SLOT_COUNT_RESET;
         active_ff     <= '0;
         depth_ff      <= '0;
         enabled_ff    <= 1'b0;
         ptr_ff        <= '0;
         pend_ff       <= 1'b0;
         found_ff      <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         slot_count_ff <= slot_count_in;
         active_ff     <= active_in;
         depth_ff      <= depth_in;
         enabled_ff    <= enabled_in;
         ptr_ff        <= ptr_in;
         pend_ff       <= pend_in;
         found_ff      <= found_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff       <= req_in;
      pend_addr_ff <= pend_addr_in;
      ow_ff        <= ow_in;
      rsp_word_ff  <= rsp_word_in;
   end

   assign busy       = (state_ff != S_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_word   = rsp_word_ff;

endmodule

// ----- rtl/rsfla_ram.sv -----
module rsfla_ram #(
   parameter int WIDTH = rsfla_pkg::IDX_W,
   parameter int DEPTH = rsfla_pkg::MAX_SLOTS
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- tb/sv/reserved_slot_free_list_allocator_core_tb.sv -----
`timescale 1ns / 1ps

import rsfla_pkg::*;

class slot_table_model;
   bit [IDX_W-1:0] free_stack [MAX_SLOTS];
   int unsigned    free_depth;
   bit             occupied [MAX_SLOTS];
   bit             enabled;
   int unsigned    active_count;
   bit [CNT_W-1:0] slot_count;
   rsp_word_type   due_results[$];
   int unsigned    mismatches;
   int unsigned    checked;
   int unsigned    overwrites;
   int unsigned    status_seen [8];

   function new();
      free_depth   = 0;
      enabled      = 1'b0;
      active_count = 0;
      slot_count   = SLOT_COUNT_RESET;
      mismatches   = 0;
      checked      = 0;
      overwrites   = 0;
      foreach (occupied[i]) occupied[i] = 1'b0;
      foreach (status_seen[i]) status_seen[i] = 0;
   endfunction

   function void write_count(input bit [CNT_W-1:0] value);
      slot_count = value;
   endfunction

   function void remove_from_stack(input int unsigned idx);
      int unsigned pos;
      pos = 0;
      while (pos < free_depth && free_stack[pos] != idx) pos++;
      if (pos < free_depth) begin
         for (int unsigned j = pos; j + 1 < free_depth; j++) free_stack[j] = free_stack[j + 1];
         free_depth--;
      end
   endfunction

   // predict the result of one accepted word and queue it
   function void take_request(input req_word_type w);
      rsp_word_type r;
      int unsigned  idx;
      r   = '0;
      idx = w.slot_index;
      case (w.operation)
         OP_INIT: begin
            active_count = (slot_count > MAX_SLOTS) ? MAX_SLOTS : slot_count;
            foreach (occupied[i]) occupied[i] = 1'b0;
            free_depth = 0;
            for (int unsigned i = RESERVED_SLOTS; i < active_count; i++) begin
               free_stack[free_depth] = IDX_W'(i);
               free_depth++;
            end
            enabled  = 1'b1;
            r.status = ST_OK;
         end
         OP_ALLOC: begin
            if (!enabled) begin
               r.status = ST_NOT_ENABLED;
            end else if (free_depth == 0) begin
               r.status = ST_FULL;
            end else begin
               free_depth--;
               occupied[free_stack[free_depth]] = 1'b1;
               r.status        = ST_OK;
               r.granted_index = free_stack[free_depth];
               r.write_valid   = 1'b1;
               r.write_handle  = w.handle;
            end
         end
         OP_ALLOC_AT: begin
            if (!enabled) begin
               r.status = ST_NOT_ENABLED;
            end else if (idx >= active_count) begin
               r.status = ST_BAD_INDEX;
            end else begin
               r.overwrote   = occupied[idx];
               occupied[idx] = 1'b1;
               remove_from_stack(idx);
               r.status        = ST_OK;
               r.granted_index = w.slot_index;
               r.write_valid   = 1'b1;
               r.write_handle  = w.handle;
            end
         end
         default: begin
            if (idx >= active_count) begin
               r.status = ST_BAD_INDEX;
            end else if (!occupied[idx]) begin
               r.status = ST_ALREADY_FREE;
            end else begin
               occupied[idx] = 1'b0;
               if (free_depth < MAX_SLOTS) begin
                  free_stack[free_depth] = w.slot_index;
                  free_depth++;
               end
               r.status        = ST_OK;
               r.granted_index = w.slot_index;
            end
         end
      endcase
      due_results.insert(due_results.size(), r);
   endfunction

   function void field_mismatch(input string name, input logic [HANDLE_W-1:0] want,
                                input logic [HANDLE_W-1:0] seen);
      mismatches++;
      if (mismatches <= 10)
         $display("%0t: result %0d %s mismatch: expected %h, got %h",
                  $time, checked, name, want, seen);
   endfunction

   function void compare_result(input rsp_word_type got);
      rsp_word_type want;
      if (due_results.size() == 0) begin
         mismatches++;
         if (mismatches <= 10) $display("%0t: unexpected result %h", $time, got);
         return;
      end
      want = due_results.pop_front();
      checked++;
      status_seen[want.status]++;
      if (want.overwrote) overwrites++;
      if (got.status !== want.status)
         field_mismatch("status", HANDLE_W'(want.status), HANDLE_W'(got.status));
      if (got.granted_index !== want.granted_index)
         field_mismatch("granted_index", HANDLE_W'(want.granted_index),
                        HANDLE_W'(got.granted_index));
      if (got.overwrote !== want.overwrote)
         field_mismatch("overwrote", HANDLE_W'(want.overwrote), HANDLE_W'(got.overwrote));
      if (got.write_valid !== want.write_valid)
         field_mismatch("write_valid", HANDLE_W'(want.write_valid),
                        HANDLE_W'(got.write_valid));
      if (got.write_handle !== want.write_handle)
         field_mismatch("write_handle", want.write_handle, got.write_handle);
   endfunction

   function int unsigned pick_occupied(input int unsigned fallback);
      int unsigned i;
      if (active_count == 0) return fallback;
      repeat (16) begin
         i = $urandom_range(0, active_count - 1);
         if (occupied[i]) return i;
      end
      return $urandom_range(0, active_count - 1);
   endfunction
endclass

module reserved_slot_free_list_allocator_core_tb;

   localparam int RANDOM_ITEMS   = 700;
   localparam int WATCHDOG_LIMIT = 20000;

   logic           clock = 1'b0;
   logic           reset;
   logic           start;
   logic           busy;
   req_word_type   req_word;
   logic           rsp_strobe;
   rsp_word_type   rsp_word;
   logic           csr_wr_en;
   logic [CNT_W-1:0] csr_wr_data;

   slot_table_model model;
   int unsigned     burst_left;
   int unsigned     idle_cycles;
   int unsigned     phases;
   int unsigned     random_sent;
   int unsigned     words_sent;

   reserved_slot_free_list_allocator_core dut (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_word    (req_word),
      .rsp_strobe  (rsp_strobe),
      .rsp_word    (rsp_word),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset && rsp_strobe) model.compare_result(rsp_word);
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout: no activity for %0d cycles", WATCHDOG_LIMIT);
            $display("CHECKS FAILED");
            $finish;
         end
      end
   end

   task automatic pace();
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         start <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 8);
      end
   endtask

   task automatic send_word(input req_word_type w);
      req_word <= w;
      start    <= 1'b1;
      do @(posedge clock); while (busy);
      model.take_request(w);
      words_sent++;
      pace();
   endtask

   task automatic send_op(input logic [OP_W-1:0] op, input int unsigned idx,
                          input logic [HANDLE_W-1:0] handle);
      req_word_type w;
      w.operation  = op;
      w.slot_index = IDX_W'(idx);
      w.handle     = handle;
      send_word(w);
   endtask

   // hold the sender until every pending result is back
   task automatic drain_results();
      if (start) start <= 1'b0;
      while (model.due_results.size() != 0) @(posedge clock);
   endtask

   task automatic write_slot_count(input logic [CNT_W-1:0] value);
      drain_results();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      model.write_count(value);
   endtask

   function automatic logic [CNT_W-1:0] pick_count(input int unsigned p);
      case (p)
         0:       return CNT_W'(5);
         1:       return CNT_W'(0);
         2:       return CNT_W'(4);
         3:       return CNT_W'(2047);
         4:       return CNT_W'(1024);
         5:       return CNT_W'(1025);
         6:       return CNT_W'(6);
         default: begin
            if ($urandom_range(0, 7) == 0) return CNT_W'($urandom_range(65, 1024));
            return CNT_W'($urandom_range(5, 40));
         end
      endcase
   endfunction

   task automatic send_random_item();
      int unsigned         r;
      int unsigned         idx;
      logic [HANDLE_W-1:0] handle;
      logic [OP_W-1:0]     op;
      r   = $urandom_range(0, 99);
      idx = $urandom_range(0, MAX_SLOTS - 1);
      case ($urandom_range(0, 15))
         0:       handle = '0;
         1:       handle = '1;
         default: handle = $urandom;
      endcase
      if (r < 3) begin
         op = OP_INIT;
      end else if (r < 38) begin
         op = OP_ALLOC;
      end else if (r < 62) begin
         op = OP_ALLOC_AT;
         if (model.active_count != 0 && $urandom_range(0, 4) != 0)
            idx = $urandom_range(0, model.active_count - 1);
      end else if (r < 94) begin
         op = OP_FREE;
         if ($urandom_range(0, 4) != 0) idx = model.pick_occupied(idx);
      end else begin
         op = OP_W'($urandom_range(0, 3));
      end
      send_op(op, idx, handle);
   endtask

   initial begin
      logic [CNT_W-1:0] count;
      int unsigned      per_phase;
      reset       <= 1'b1;
      start       <= 1'b0;
      req_word    <= '0;
      csr_wr_en   <= 1'b0;
      csr_wr_data <= '0;
      model       = new();
      burst_left  = 0;
      idle_cycles = 0;
      phases      = 0;
      random_sent = 0;
      words_sent  = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      send_op(OP_ALLOC, 0, 32'h1234_5678);
      send_op(OP_ALLOC_AT, 3, 32'h0BAD_F00D);
      send_op(OP_FREE, 0, '0);
      send_op(OP_FREE, MAX_SLOTS - 1, '1);
      write_slot_count(CNT_W'(8));
      send_op(OP_INIT, 0, '0);
      send_op(OP_ALLOC, 0, '1);
      send_op(OP_ALLOC, MAX_SLOTS - 1, '0);
      send_op(OP_ALLOC, 0, 32'h0000_0001);
      send_op(OP_ALLOC, 0, 32'h8000_0000);
      send_op(OP_ALLOC_AT, 0, 32'hA5A5_A5A5);
      send_op(OP_ALLOC_AT, 7, 32'h5A5A_5A5A);
      send_op(OP_ALLOC_AT, 8, 32'hDEAD_BEEF);
      send_op(OP_ALLOC_AT, MAX_SLOTS - 1, '1);
      send_op(OP_FREE, 7, '0);
      send_op(OP_FREE, 7, '0);
      send_op(OP_FREE, 8, '0);
      send_op(OP_FREE, MAX_SLOTS - 1, '0);
      send_op(OP_ALLOC_AT, 7, 32'h7777_7777);
      send_op(OP_ALLOC, 0, 32'h1111_1111);
      send_op(OP_FREE, 6, '0);
      send_op(OP_FREE, 5, '0);
      send_op(OP_ALLOC, 0, 32'h2222_2222);
      send_op(OP_INIT, 0, '0);
      send_op(OP_ALLOC, 0, 32'h3333_3333);

      while (random_sent < RANDOM_ITEMS) begin
         count = pick_count(phases);
         write_slot_count(count);
         if (phases < 7 || $urandom_range(0, 4) != 0)
            send_op(OP_INIT, $urandom_range(0, MAX_SLOTS - 1), $urandom);
         per_phase = (count > 128) ? 12 : 40;
         repeat (per_phase) begin
            send_random_item();
            random_sent++;
            if ($urandom_range(0, 39) == 0) drain_results();
         end
         phases++;
      end

      drain_results();
      repeat (8) @(posedge clock);

      $display("Run covered %0d words over %0d slot-count phases; results ok %0d,",
               words_sent, phases + 1, model.status_seen[ST_OK]);
      $display("not enabled %0d, full %0d, bad index %0d, already free %0d, overwrites %0d",
               model.status_seen[ST_NOT_ENABLED], model.status_seen[ST_FULL],
               model.status_seen[ST_BAD_INDEX], model.status_seen[ST_ALREADY_FREE],
               model.overwrites);
      if (model.due_results.size() != 0)
         $display("%0d expected results never arrived", model.due_results.size());
      if (model.mismatches == 0 && model.due_results.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("%0d mismatches", model.mismatches);
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

// ----- files.f -----
rtl/rsfla_pkg.sv
rtl/rsfla_ram.sv
rtl/reserved_slot_free_list_allocator_core.sv
tb/sv/reserved_slot_free_list_allocator_core_tb.sv
